>>> design/buddy_allocator_macros.svh
// ---------------------------------------------------------------------------
// Buddy allocator assertion macros
// Shorthand for the concurrent checks used in the allocator modules.
// ---------------------------------------------------------------------------
`ifndef BUDDY_ALLOCATOR_MACROS_SVH
`define BUDDY_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/ba_pkg.sv
// ---------------------------------------------------------------------------
// Buddy allocator package
// Sizes, codes, the block table entry layout and the controller interface.
// ---------------------------------------------------------------------------
package ba_pkg;

   // Memory holds 2^LOG_MEM units; owners are OWNER_W bits wide.
   localparam int LOG_MEM   = 10;
   localparam int OWNER_W   = 8;
   localparam int MEM_UNITS = 1 << LOG_MEM;
   localparam int ORD_W     = $clog2(LOG_MEM + 1);
   localparam int PTR_W     = LOG_MEM + 1;

   // Request kinds.
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // Error codes.
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_NO_SPACE = 2'd1;
   localparam logic [1:0] ERR_NO_OWNER = 2'd2;

   // One block table entry, kept at the start address of a block.
   typedef struct packed {
      logic               head;
      logic               is_free;
      logic [ORD_W-1:0]   ord;
      logic [OWNER_W-1:0] who;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clr_step;
      logic start;
      logic scan_rd;
      logic scan_next;
      logic hit;
      logic split_step;
      logic alloc_fin;
      logic merge_rd;
      logic merge_step;
      logic merge_fin;
      logic fail;
      logic load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic ptr_end;
      logic hit;
      logic is_free_req;
      logic cur_gt_want;
      logic cur_top;
      logic buddy_ok;
   } stat_type;

endpackage

>>> design/ba_req_if.sv
// ---------------------------------------------------------------------------
// Buddy allocator request channel
// Valid/ready channel carrying one allocate or free request.
// ---------------------------------------------------------------------------
interface ba_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [3:0] order;
   logic [7:0] owner;

   modport source (output valid, req_type, order, owner, input ready);
   modport sink   (input valid, req_type, order, owner, output ready);
endinterface

>>> design/ba_rsp_if.sv
// ---------------------------------------------------------------------------
// Buddy allocator response channel
// Valid/ready channel carrying one result per request.
// ---------------------------------------------------------------------------
interface ba_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [1:0]  err_code;
   logic [15:0] start_addr;
   logic [3:0]  block_order;

   modport source (output valid, ok, err_code, start_addr, block_order, input ready);
   modport sink   (input valid, ok, err_code, start_addr, block_order, output ready);
endinterface

>>> design/ba_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module ba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> design/ba_datapath.sv
// ---------------------------------------------------------------------------
// Buddy allocator datapath
// Walk pointer, block order, request fields, the block table and results.
// ---------------------------------------------------------------------------
module ba_datapath import ba_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   output stat_type        stat,
   input  logic            req_type,
   input  logic [3:0]      req_order,
   input  logic [7:0]      req_owner,
   output logic            rsp_ok,
   output logic [1:0]      rsp_err_code,
   output logic [15:0]     rsp_start_addr,
   output logic [3:0]      rsp_block_order
);
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [ORD_W-1:0]   cur_ff, cur_in;
   logic [3:0]         want_ff;
   logic [OWNER_W-1:0] owner_ff;
   logic               kind_ff;
   logic [LOG_MEM-1:0] orig_addr_ff;
   logic [ORD_W-1:0]   orig_ord_ff;
   logic               res_ok_ff;
   logic [1:0]         res_err_ff;
   logic [15:0]        res_addr_ff;
   logic [3:0]         res_ord_ff;
   logic               out_ok_ff;
   logic [1:0]         out_err_ff;
   logic [15:0]        out_addr_ff;
   logic [3:0]         out_ord_ff;

   logic               wr_en, rd_en;
   logic [LOG_MEM-1:0] wr_addr, rd_addr, base, buddy, half_addr;
   entry_type          wr_ent, rd_ent;
   logic [ENTRY_W-1:0] rd_bits;

   assign base      = ptr_ff[LOG_MEM-1:0];
   assign buddy     = base ^ (LOG_MEM'(1) << cur_ff);
   assign half_addr = base + (LOG_MEM'(1) << (cur_ff - ORD_W'(1)));
   assign rd_ent    = entry_type'(rd_bits);

   // Table port selection.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = base;
      wr_ent  = '0;
      rd_en   = cmd.scan_rd | cmd.merge_rd;
      rd_addr = cmd.merge_rd ? buddy : base;
      if (cmd.clr_step) begin
         wr_en = 1'b1;
         if (ptr_ff == '0) begin
            wr_ent.head    = 1'b1;
            wr_ent.is_free = 1'b1;
            wr_ent.ord     = ORD_W'(LOG_MEM);
         end
      end else if (cmd.split_step) begin
         wr_en          = 1'b1;
         wr_addr        = half_addr;
         wr_ent.head    = 1'b1;
         wr_ent.is_free = 1'b1;
         wr_ent.ord     = cur_ff - ORD_W'(1);
      end else if (cmd.alloc_fin) begin
         wr_en       = 1'b1;
         wr_ent.head = 1'b1;
         wr_ent.ord  = cur_ff;
         wr_ent.who  = owner_ff;
      end else if (cmd.merge_step) begin
         wr_en   = 1'b1;
         wr_addr = (base > buddy) ? base : buddy;
      end else if (cmd.merge_fin) begin
         wr_en          = 1'b1;
         wr_ent.head    = 1'b1;
         wr_ent.is_free = 1'b1;
         wr_ent.ord     = cur_ff;
      end
   end

   ba_ram #(.WIDTH(ENTRY_W), .DEPTH(MEM_UNITS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ENTRY_W'(wr_ent)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   // Walk pointer and current order.
   always_comb begin
      ptr_in = ptr_ff;
      cur_in = cur_ff;
      if (cmd.clr_step) begin
         ptr_in = ptr_ff + PTR_W'(1);
      end else if (cmd.start) begin
         ptr_in = '0;
      end else if (cmd.scan_next) begin
         // A non-head entry should not be met; step by one to stay safe.
         ptr_in = ptr_ff + (rd_ent.head ? (PTR_W'(1) << rd_ent.ord) : PTR_W'(1));
      end else if (cmd.hit) begin
         cur_in = rd_ent.ord;
      end else if (cmd.split_step) begin
         cur_in = cur_ff - ORD_W'(1);
      end else if (cmd.merge_step) begin
         ptr_in = PTR_W'((base < buddy) ? base : buddy);
         cur_in = cur_ff + ORD_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
      end
   end

   // Request fields, hit record, result and output registers.
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (cmd.start) begin
         kind_ff  <= req_type;
         want_ff  <= req_order;
         owner_ff <= OWNER_W'(req_owner);
      end
      if (cmd.hit) begin
         orig_addr_ff <= base;
         orig_ord_ff  <= rd_ent.ord;
      end
      if (cmd.alloc_fin) begin
         res_ok_ff   <= 1'b1;
         res_err_ff  <= ERR_NONE;
         res_addr_ff <= 16'(base);
         res_ord_ff  <= 4'(cur_ff);
      end else if (cmd.merge_fin) begin
         res_ok_ff   <= 1'b1;
         res_err_ff  <= ERR_NONE;
         res_addr_ff <= 16'(orig_addr_ff);
         res_ord_ff  <= 4'(orig_ord_ff);
      end else if (cmd.fail) begin
         res_ok_ff   <= 1'b0;
         res_err_ff  <= (kind_ff == REQ_FREE) ? ERR_NO_OWNER : ERR_NO_SPACE;
         res_addr_ff <= '0;
         res_ord_ff  <= '0;
      end
      if (cmd.load_rsp) begin
         out_ok_ff   <= res_ok_ff;
         out_err_ff  <= res_err_ff;
         out_addr_ff <= res_addr_ff;
         out_ord_ff  <= res_ord_ff;
      end
   end

   // Status toward the controller.
   always_comb begin
      stat.ptr_end     = ptr_ff[LOG_MEM];
      stat.is_free_req = (kind_ff == REQ_FREE);
      if (kind_ff == REQ_FREE) begin
         stat.hit = rd_ent.head & ~rd_ent.is_free & (rd_ent.who == owner_ff);
      end else begin
         stat.hit = rd_ent.head & rd_ent.is_free & (rd_ent.ord >= want_ff);
      end
      stat.cur_gt_want = (cur_ff > want_ff);
      stat.cur_top     = (cur_ff == ORD_W'(LOG_MEM));
      stat.buddy_ok    = rd_ent.head & rd_ent.is_free & (rd_ent.ord == cur_ff);
   end

   assign rsp_ok          = out_ok_ff;
   assign rsp_err_code    = out_err_ff;
   assign rsp_start_addr  = out_addr_ff;
   assign rsp_block_order = out_ord_ff;
endmodule

>>> design/ba_ctrl.sv
// ---------------------------------------------------------------------------
// Buddy allocator controller
// Sequences table clearing, the block walk, splitting, merging and replies.
// ---------------------------------------------------------------------------
`include "buddy_allocator_macros.svh"

module ba_ctrl import ba_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);
   localparam logic [3:0] S_CLEAR     = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_SCAN_RD   = 4'd2;
   localparam logic [3:0] S_SCAN_CHK  = 4'd3;
   localparam logic [3:0] S_SPLIT     = 4'd4;
   localparam logic [3:0] S_MERGE_RD  = 4'd5;
   localparam logic [3:0] S_MERGE_CHK = 4'd6;
   localparam logic [3:0] S_MERGE_END = 4'd7;
   localparam logic [3:0] S_DONE      = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         S_CLEAR: begin
            if (stat.ptr_end) begin
               state_in = S_IDLE;
            end else begin
               cmd.clr_step = 1'b1;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.start = 1'b1;
               state_in  = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (stat.ptr_end) begin
               cmd.fail = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (stat.hit) begin
               cmd.hit  = 1'b1;
               state_in = stat.is_free_req ? S_MERGE_RD : S_SPLIT;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN_RD;
            end
         end
         S_SPLIT: begin
            if (stat.cur_gt_want) begin
               cmd.split_step = 1'b1;
            end else begin
               cmd.alloc_fin = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_MERGE_RD: begin
            if (stat.cur_top) begin
               state_in = S_MERGE_END;
            end else begin
               cmd.merge_rd = 1'b1;
               state_in     = S_MERGE_CHK;
            end
         end
         S_MERGE_CHK: begin
            if (stat.buddy_ok) begin
               cmd.merge_step = 1'b1;
               state_in       = S_MERGE_RD;
            end else begin
               state_in = S_MERGE_END;
            end
         end
         S_MERGE_END: begin
            cmd.merge_fin = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and response valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `BA_ASSERT_IMP(a_no_req_in_clear, clock, reset, state_ff == S_CLEAR, !req_ready, "request taken during clear")
   `BA_ASSERT_NEXT(a_accept_starts_walk, clock, reset, accept, state_ff == S_SCAN_RD, "walk did not start")
   `BA_ASSERT_IMP(a_one_table_op, clock, reset, cmd.scan_rd || cmd.merge_rd, !(cmd.split_step || cmd.merge_step || cmd.alloc_fin || cmd.merge_fin), "table read and write at once")
   `BA_ASSERT_NEXT(a_rsp_loaded, clock, reset, cmd.load_rsp, rsp_valid, "response not presented")
endmodule

>>> design/buddy_allocator.sv
// ---------------------------------------------------------------------------
// Buddy allocator
// Binary buddy allocator with a block table held in a generic RAM.
// ---------------------------------------------------------------------------
// After reset the block table is swept once, one entry per cycle, and no
// request is taken until that ends. A request then visits the block heads in
// address order, and each head costs one read of the table memory. An
// allocate then splits the block it found until it has the wanted order. A
// free merges the block with its buddy until the buddy cannot be merged or
// the block covers the whole memory. A request that finds no block fails.
// The reply is then loaded into the output register. One request is worked
// on at a time; a new one is taken while the last reply waits.
module buddy_allocator import ba_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   ba_req_if.sink   req_chan,
   ba_rsp_if.source rsp_chan
);
   cmd_type  cmd;
   stat_type stat;

   // Sequencer.
   ba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Table and registers.
   ba_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_type        (req_chan.req_type),
      .req_order       (req_chan.order),
      .req_owner       (req_chan.owner),
      .rsp_ok          (rsp_chan.ok),
      .rsp_err_code    (rsp_chan.err_code),
      .rsp_start_addr  (rsp_chan.start_addr),
      .rsp_block_order (rsp_chan.block_order)
   );
endmodule
